@@ design/wfmh_pkg.sv @@
// Shared constants, types and helpers for the whitespace-filtered murmur2 hash.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package wfmh_pkg;

    localparam int unsigned HASH_W   = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned S_DATA_W = 40;   // filtered_length + byte_value, whole bytes
    localparam int unsigned M_DATA_W = 32;

    localparam logic [HASH_W-1:0] MIX_MULT = 32'd1540483477;
    localparam int unsigned SHIFT_MIX  = 24;
    localparam int unsigned SHIFT_FIN1 = 13;
    localparam int unsigned SHIFT_FIN2 = 15;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    localparam logic [BYTE_W-1:0] CHR_TAB   = 8'd9;
    localparam logic [BYTE_W-1:0] CHR_LF    = 8'd10;
    localparam logic [BYTE_W-1:0] CHR_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CHR_SPACE = 8'd32;

    localparam logic [1:0] LAST_LANE = 2'd3;

    typedef struct packed {
        logic              en;
        logic [HASH_W-1:0] operand;
    } mul_req_t;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_K1   = 8'b0000_0010,
        ST_K2   = 8'b0000_0100,
        ST_H    = 8'b0000_1000,
        ST_HX   = 8'b0001_0000,
        ST_FP   = 8'b0010_0000,
        ST_F1   = 8'b0100_0000,
        ST_F2   = 8'b1000_0000
    } state_t;

    function automatic logic is_dropped(input logic [BYTE_W-1:0] b);
        return (b == CHR_TAB) || (b == CHR_LF) || (b == CHR_CR) || (b == CHR_SPACE);
    endfunction

endpackage

@@ design/wfmh_mul.sv @@
// Shared constant multiplier: operand times the mixing constant, registered.
// Depends on wfmh_pkg for the constant and the request struct.
`timescale 1ns / 1ps

module wfmh_mul
    import wfmh_pkg::*;
(
    input  logic              aclk,
    input  mul_req_t          req,
    output logic [HASH_W-1:0] product_reg
);

    logic [HASH_W-1:0] product_next;

    assign product_next = HASH_W'(req.operand * MIX_MULT);

    // Hold the product while no multiply is issued
    always_ff @(posedge aclk) begin
        if (req.en) begin
            product_reg <= product_next;
        end
    end

endmodule

@@ design/whitespace_filtered_murmur2_hash.sv @@
// Top level of the whitespace-filtered murmur2 hash: sequencer and hash state.
// Depends on wfmh_pkg and the shared multiplier wfmh_mul.
`timescale 1ns / 1ps

// A start word (tuser = 0) loads the hash with 1 xor the kept-byte count in
// tdata[31:0]; data words (tuser = 1) carry one raw byte in tdata[39:32] and
// tlast marks the final byte. Tab, line feed, carriage return and space are
// dropped. Start words, dropped bytes and bytes that do not complete a 32-bit
// group are taken without leaving the idle state. A byte that completes a
// group passes through states K1, K2, H and HX, as its three multiplies go one
// after another through a single registered constant multiplier. A last byte
// adds FP (only while a partial group is held), F1 and F2 for the final
// avalanche, and waits in F2 while an earlier hash is not yet taken; then the
// hash sits in an output register and the input side is ready while it waits.

module whitespace_filtered_murmur2_hash
    import wfmh_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [31:0] filtered_length, [39:32] byte_value
    input  logic                s_tuser,   // [0] command
    input  logic                s_tlast,   // last_byte
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [31:0] hash_value
);

    state_t            state_reg, state_next;
    logic [HASH_W-1:0] h_reg, h_next;
    logic [HASH_W-1:0] pw_reg, pw_next;
    logic [HASH_W-1:0] k_reg, k_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic              last_reg, last_next;
    logic              use_mul_reg, use_mul_next;
    logic              m_valid_reg, m_valid_next;
    logic [HASH_W-1:0] hash_reg, hash_next;

    mul_req_t          mul_req;
    logic [HASH_W-1:0] mul_q;

    logic              accept;
    logic [BYTE_W-1:0] in_byte;
    logic              kept;
    logic [HASH_W-1:0] packed_word;
    logic [1:0]        cnt_inc;
    logic [HASH_W-1:0] fin_src;

    wfmh_mul u_mul (
        .aclk        (aclk),
        .req         (mul_req),
        .product_reg (mul_q)
    );

    assign s_tready    = (state_reg == ST_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign in_byte     = s_tdata[S_DATA_W-1 -: BYTE_W];
    assign kept        = !is_dropped(in_byte);
    assign packed_word = pw_reg | (HASH_W'(in_byte) << {cnt_reg, 3'b000});
    assign cnt_inc     = cnt_reg + 2'd1;
    assign fin_src     = use_mul_reg ? mul_q : h_reg;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = hash_reg;

    always_comb begin
        state_next   = state_reg;
        h_next       = h_reg;
        pw_next      = pw_reg;
        k_next       = k_reg;
        cnt_next     = cnt_reg;
        last_next    = last_reg;
        use_mul_next = use_mul_reg;
        m_valid_next = m_valid_reg && !m_tready;
        hash_next    = hash_reg;
        mul_req      = '{en: 1'b0, operand: pw_reg};

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == CMD_START) begin
                        h_next   = 1 ^ s_tdata[HASH_W-1:0];
                        pw_next  = '0;
                        cnt_next = '0;
                    end else begin
                        last_next    = s_tlast;
                        use_mul_next = 1'b0;
                        if (kept && cnt_reg == LAST_LANE) begin
                            pw_next    = packed_word;
                            cnt_next   = '0;
                            state_next = ST_K1;
                        end else begin
                            if (kept) begin
                                pw_next  = packed_word;
                                cnt_next = cnt_inc;
                            end
                            if (s_tlast) begin
                                // Fold in the partial group only if bytes are held
                                state_next = (cnt_next != 2'd0) ? ST_FP : ST_F1;
                            end
                        end
                    end
                end
            end
            ST_K1: begin
                mul_req    = '{en: 1'b1, operand: pw_reg};
                state_next = ST_K2;
            end
            ST_K2: begin
                mul_req    = '{en: 1'b1, operand: mul_q ^ (mul_q >> SHIFT_MIX)};
                pw_next    = '0;
                state_next = ST_H;
            end
            ST_H: begin
                k_next     = mul_q;
                mul_req    = '{en: 1'b1, operand: h_reg};
                state_next = ST_HX;
            end
            ST_HX: begin
                h_next     = mul_q ^ k_reg;
                state_next = last_reg ? ST_F1 : ST_IDLE;
            end
            ST_FP: begin
                mul_req      = '{en: 1'b1, operand: h_reg ^ pw_reg};
                use_mul_next = 1'b1;
                state_next   = ST_F1;
            end
            ST_F1: begin
                mul_req    = '{en: 1'b1, operand: fin_src ^ (fin_src >> SHIFT_FIN1)};
                state_next = ST_F2;
            end
            ST_F2: begin
                // Wait here while the previous hash still sits unread
                if (!m_valid_reg || m_tready) begin
                    hash_next    = mul_q ^ (mul_q >> SHIFT_FIN2);
                    m_valid_next = 1'b1;
                    h_next       = '0;
                    pw_next      = '0;
                    cnt_next     = '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            h_reg       <= '0;
            pw_reg      <= '0;
            cnt_reg     <= '0;
            last_reg    <= 1'b0;
            use_mul_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            h_reg       <= h_next;
            pw_reg      <= pw_next;
            cnt_reg     <= cnt_next;
            last_reg    <= last_next;
            use_mul_reg <= use_mul_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg    <= k_next;
        hash_reg <= hash_next;
    end

endmodule

@@ design/wfmh_checker.sv @@
// Port-level checks for the whitespace-filtered murmur2 hash, with its bind.
// Depends on wfmh_pkg and binds to whitespace_filtered_murmur2_hash.
`timescale 1ns / 1ps

module wfmh_checker
    import wfmh_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                s_tuser,
    input logic                s_tlast,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // A start word never stalls the input side
    a_start_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == CMD_START) |=> s_tready)
        else $error("input not ready after a start word");

    // The last byte always leads into the finishing sequence
    a_last_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == CMD_DATA) && s_tlast |=> !s_tready)
        else $error("input ready straight after a last byte");

    // A result appears only at the end of a busy stretch
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a finishing sequence");

endmodule

bind whitespace_filtered_murmur2_hash wfmh_checker u_wfmh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/whitespace_filtered_murmur2_hash_test.sv @@
// Self-checking testbench for the whitespace-filtered murmur2 hash block.
// Predicts each hash from the accepted stream words; needs wfmh_pkg and the RTL.
`timescale 1ns / 1ps

module whitespace_filtered_murmur2_hash_test;
    import wfmh_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned TAIL_CYCLES = 24;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = CMD_START;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // Predicted hash state
    logic [HASH_W-1:0] model_hash = '0;
    logic [HASH_W-1:0] model_word = '0;
    logic [1:0]        model_fill = '0;

    logic [HASH_W-1:0] expected_hashes[$];
    int unsigned       items_sent = 0;
    int unsigned       failures = 0;
    int unsigned       cycle_count = 0;
    int unsigned       send_idle_pct = 0;
    int unsigned       recv_idle_pct = 0;

    whitespace_filtered_murmur2_hash uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic byte_is_blank(input logic [BYTE_W-1:0] b);
        return b == CHR_TAB || b == CHR_LF || b == CHR_CR || b == CHR_SPACE;
    endfunction

    function automatic logic [HASH_W-1:0] mix_block(input logic [HASH_W-1:0] h,
                                                    input logic [HASH_W-1:0] k);
        logic [HASH_W-1:0] m;
        logic [HASH_W-1:0] hm;
        m  = k * MIX_MULT;
        m  = m ^ (m >> SHIFT_MIX);
        m  = m * MIX_MULT;
        hm = h * MIX_MULT;
        return hm ^ m;
    endfunction

    // Advance the predicted state by one accepted word; flag a hash when one is due.
    function automatic void hash_model_step(input logic cmd, input logic [HASH_W-1:0] len,
                                            input logic [BYTE_W-1:0] b, input logic last,
                                            output logic got, output logic [HASH_W-1:0] hash);
        logic [HASH_W-1:0] lane;
        logic [HASH_W-1:0] h;
        got  = 1'b0;
        hash = '0;
        if (cmd == CMD_START) begin
            model_hash = len ^ 32'd1;
            model_word = '0;
            model_fill = '0;
        end else begin
            if (!byte_is_blank(b)) begin
                lane = {24'd0, b};
                lane = lane << (8 * model_fill);
                model_word = model_word | lane;
                if (model_fill == LAST_LANE) begin
                    model_hash = mix_block(model_hash, model_word);
                    model_word = '0;
                    model_fill = '0;
                end else begin
                    model_fill = model_fill + 2'd1;
                end
            end
            if (last) begin
                h = model_hash;
                if (model_fill != 2'd0) begin
                    h = h ^ model_word;
                    h = h * MIX_MULT;
                end
                h = h ^ (h >> SHIFT_FIN1);
                h = h * MIX_MULT;
                h = h ^ (h >> SHIFT_FIN2);
                got  = 1'b1;
                hash = h;
                model_hash = '0;
                model_word = '0;
                model_fill = '0;
            end
        end
    endfunction

    task automatic send_word(input logic cmd, input logic [HASH_W-1:0] len,
                             input logic [BYTE_W-1:0] b, input logic last);
        logic              got;
        logic [HASH_W-1:0] h;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {b, len};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        hash_model_step(cmd, len, b, last, got, h);
        if (got) expected_hashes.push_back(h);
        items_sent++;
    endtask

    // Hold the sender off until every pending hash has been taken.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_hashes.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        // bytes with no start word, straight after reset
        send_word(CMD_DATA, $urandom, 8'h41, 1'b0);
        send_word(CMD_DATA, $urandom, 8'h00, 1'b1);
        // largest length; start carries byte and last that must be ignored
        send_word(CMD_START, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        repeat (4) send_word(CMD_DATA, 32'h0, 8'hFF, 1'b0);
        send_word(CMD_DATA, 32'h0, CHR_TAB, 1'b1);          // blank last, empty lane
        // zero length, each blank byte but tab, two kept bytes left over
        send_word(CMD_START, 32'h0, 8'h00, 1'b0);
        send_word(CMD_DATA, 32'hFFFF_FFFF, CHR_LF, 1'b0);
        send_word(CMD_DATA, 32'h0, CHR_CR, 1'b0);
        send_word(CMD_DATA, 32'h0, CHR_SPACE, 1'b0);
        send_word(CMD_DATA, 32'h0, 8'h00, 1'b0);
        send_word(CMD_DATA, 32'h0, 8'h80, 1'b1);
        // three kept bytes left over
        send_word(CMD_START, 32'd3, 8'h00, 1'b0);
        send_word(CMD_DATA, 32'h0, 8'h61, 1'b0);
        send_word(CMD_DATA, 32'h0, 8'h62, 1'b0);
        send_word(CMD_DATA, 32'h0, 8'h63, 1'b1);
        // restart in the middle of a message, one kept byte left over
        send_word(CMD_START, 32'd5, 8'h00, 1'b0);
        send_word(CMD_DATA, 32'h0, 8'h78, 1'b0);
        send_word(CMD_START, 32'd1, 8'h00, 1'b0);
        send_word(CMD_DATA, 32'h0, 8'h79, 1'b1);
    endtask

    task automatic send_message();
        logic [BYTE_W-1:0] body[$];
        logic [BYTE_W-1:0] b;
        int unsigned       n_raw;
        int unsigned       kept;
        int unsigned       mode;
        int unsigned       cut;
        n_raw = ($urandom_range(9) == 0) ? $urandom_range(64, 20) : $urandom_range(12, 1);
        kept  = 0;
        for (int i = 0; i < n_raw; i++) begin
            if ($urandom_range(99) < 20) begin
                case ($urandom_range(3))
                    0: b = CHR_TAB;
                    1: b = CHR_LF;
                    2: b = CHR_CR;
                    default: b = CHR_SPACE;
                endcase
            end else begin
                b = BYTE_W'($urandom_range(255));
                if (!byte_is_blank(b)) kept++;
            end
            body.push_back(b);
        end
        mode = $urandom_range(99);
        if (mode < 80) begin
            send_word(CMD_START, kept, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
        end else if (mode < 90) begin
            send_word(CMD_START, $urandom, BYTE_W'($urandom_range(255)),
                      1'($urandom_range(1)));
        end else if (mode >= 95) begin
            // broken message: drop part of it, then start over
            send_word(CMD_START, $urandom, BYTE_W'($urandom_range(255)),
                      1'($urandom_range(1)));
            cut = $urandom_range(n_raw);
            for (int i = 0; i < cut; i++) send_word(CMD_DATA, $urandom, body[i], 1'b0);
            send_word(CMD_START, kept, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
        end
        for (int i = 0; i < n_raw; i++) begin
            send_word(CMD_DATA, $urandom, body[i], i == n_raw - 1);
        end
    endtask

    task automatic test_random_messages(input int unsigned send_pct,
                                        input int unsigned recv_pct,
                                        input int unsigned n_items);
        int unsigned stop_at;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) send_message();
    endtask

    // Compare each hash taken from the block with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_hashes.size() == 0) begin
                $error("hash_value: expected none, actual %08h", m_tdata);
                failures++;
            end else begin
                if (m_tdata[HASH_W-1:0] !== expected_hashes[0]) begin
                    $error("hash_value: expected %08h, actual %08h",
                           expected_hashes[0], m_tdata);
                    failures++;
                end
                void'(expected_hashes.pop_front());
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        send_idle_pct = 14;
        recv_idle_pct = 66;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        wait_for_results();
        test_random_messages(14, 66, 420);
        wait_for_results();
        test_random_messages(66, 14, 420);
        wait_for_results();
        test_random_messages(0, 0, 410);
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (failures == 0 && expected_hashes.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
